[src/ivcs_pkg.sv]
// Shared constants and types for the integer vector cosine similarity block.
// Holds widths, status codes and the sequencer and accumulate-target enums.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ivcs_pkg;

   localparam int MAX_LEN  = 4096;
   localparam int CNT_W    = $clog2(MAX_LEN + 1);
   localparam int ELEM_W   = 16;
   localparam int MAG_W    = 16;
   localparam int LIMB_W   = 22;
   localparam int PROD_W   = 2 * LIMB_W;
   localparam int DOT_W    = 44;
   localparam int NORM_W   = 43;
   localparam int ACC_W    = 4 * LIMB_W;
   localparam int FRAC_SH  = 30;
   localparam int WIDE_W   = ACC_W + FRAC_SH;
   localparam int Q_W      = 15;
   localparam int COS_W    = 16;
   localparam int STATUS_W = 2;
   localparam int STEP_W   = 4;
   localparam int BIT_W    = 4;

   localparam logic [STEP_W-1:0] ELEM_LAST_STEP = STEP_W'(3);
   localparam logic [STEP_W-1:0] MUL_LAST_STEP  = STEP_W'(8);
   localparam logic [BIT_W-1:0]  Q_TOP_BIT      = BIT_W'(Q_W - 1);

   localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_ZERO = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_LONG = 2'd2;

   localparam logic [1:0] SH_NONE = 2'd0;
   localparam logic [1:0] SH_ONE  = 2'd1;
   localparam logic [1:0] SH_TWO  = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ELEM,
      ST_CHECK,
      ST_MUL,
      ST_SADD,
      ST_SCMP,
      ST_DONE
   } st_type;

   typedef enum logic [2:0] {
      DST_NONE,
      DST_NORM_A,
      DST_NORM_B,
      DST_DOT,
      DST_P,
      DST_R
   } dst_type;

endpackage

`default_nettype wire

[src/integer_vector_cosine_similarity.sv]
// Integer vector cosine similarity: accumulates dot product and norms, then
// finds the Q1.15 cosine with a shared 22x22 multiplier and a bit search.
// Depends on ivcs_pkg.
//
//   Channel  Ports                               Direction  Transaction
//   req      req_valid/ready, elem_a/b, last     in         one element pair
//   rsp      rsp_valid/ready, cosine, status     out        one result per vector
//
// An element pair is accepted, then sends three products and a drain step
// through the shared multiplier; a pair past MAX_LEN is only flagged.
// After a pair marked last, a zero norm or long vector ends at once; otherwise
// the two products run in limbs on the multiplier, then the 15-bit search.
// Synchronous reset clears dot, norms, count and overflow; a stalled result holds
// the output register, and the block waits before loading the next one.
`timescale 1ns / 1ps
`default_nettype none

module integer_vector_cosine_similarity (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output      logic                                req_ready,
   input  wire logic signed [ivcs_pkg::ELEM_W-1:0]  req_elem_a,
   input  wire logic signed [ivcs_pkg::ELEM_W-1:0]  req_elem_b,
   input  wire logic                                req_last,
   output      logic                                rsp_valid,
   input  wire logic                                rsp_ready,
   output      logic signed [ivcs_pkg::COS_W-1:0]   rsp_cosine,
   output      logic        [ivcs_pkg::STATUS_W-1:0] rsp_status
);

   import ivcs_pkg::*;

   st_type                state_ff, state_in;
   logic [STEP_W-1:0]     step_ff, step_in;

   logic [MAG_W-1:0]      a_mag_ff, a_mag_in;
   logic [MAG_W-1:0]      b_mag_ff, b_mag_in;
   logic                  neg_ab_ff, neg_ab_in;
   logic                  last_ff, last_in;

   logic [LIMB_W-1:0]     op_x, op_y;
   dst_type               dst_issue;
   logic [1:0]            sh_issue;
   logic                  neg_issue;

   logic [PROD_W-1:0]     prod_ff, prod_in;
   dst_type               dst_ff, dst_in;
   logic [1:0]            sh_ff, sh_in;
   logic                  neg_ff, neg_in;

   logic [DOT_W-1:0]      dot_ff, dot_in;
   logic [NORM_W-1:0]     norm_a_ff, norm_a_in;
   logic [NORM_W-1:0]     norm_b_ff, norm_b_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic                  ovf_ff, ovf_in;

   logic [NORM_W-1:0]     dabs_ff, dabs_in;
   logic [ACC_W-1:0]      p_ff, p_in;
   logic [ACC_W-1:0]      r_ff, r_in;
   logic [WIDE_W-1:0]     t_ff, t_in;
   logic [WIDE_W-1:0]     u_ff, u_in;
   logic [WIDE_W-1:0]     tc_ff, tc_in;
   logic [WIDE_W-1:0]     uc_ff, uc_in;
   logic [Q_W-1:0]        q_ff, q_in;
   logic [BIT_W-1:0]      bit_ff, bit_in;
   logic [STATUS_W-1:0]   res_status_ff, res_status_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [COS_W-1:0]      rsp_cosine_ff, rsp_cosine_in;
   logic [STATUS_W-1:0]   rsp_status_ff, rsp_status_in;

   logic                  accept;
   logic                  full;
   logic                  norm_zero;
   logic                  done_go;
   logic [ACC_W-1:0]      prod_shifted;
   logic [WIDE_W-1:0]     p_wide;
   logic [WIDE_W-1:0]     r_scaled;
   logic [DOT_W-1:0]      dot_neg;
   logic [COS_W-1:0]      q_ext;

   function automatic logic [LIMB_W-1:0] limb_of(input logic [NORM_W-1:0] v,
                                                 input logic sel);
      logic [LIMB_W-1:0] res;
      if (sel) begin
         res = LIMB_W'(v[NORM_W-1:LIMB_W]);
      end else begin
         res = v[LIMB_W-1:0];
      end
      return res;
   endfunction

   assign full      = (count_ff == CNT_W'(MAX_LEN));
   assign norm_zero = (norm_a_ff == '0) || (norm_b_ff == '0);
   assign accept    = req_valid && req_ready;
   assign done_go   = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);
   assign dot_neg   = ~dot_ff + DOT_W'(1);
   assign p_wide    = WIDE_W'(p_ff);
   assign r_scaled  = {r_ff, {FRAC_SH{1'b0}}};
   assign q_ext     = {1'b0, q_ff};

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (!full) begin
                  state_in = ST_ELEM;
               end else if (req_last) begin
                  state_in = ST_CHECK;
               end
            end
         end
         ST_ELEM: begin
            if (step_ff == ELEM_LAST_STEP) begin
               state_in = last_ff ? ST_CHECK : ST_IDLE;
            end
         end
         ST_CHECK: begin
            state_in = (ovf_ff || norm_zero) ? ST_DONE : ST_MUL;
         end
         ST_MUL: begin
            if (step_ff == MUL_LAST_STEP) begin
               state_in = ST_SADD;
            end
         end
         ST_SADD: begin
            state_in = ST_SCMP;
         end
         ST_SCMP: begin
            state_in = (bit_ff == '0) ? ST_DONE : ST_SADD;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready = (state_ff == ST_IDLE);
      op_x      = '0;
      op_y      = '0;
      dst_issue = DST_NONE;
      sh_issue  = SH_NONE;
      neg_issue = 1'b0;
      case (state_ff)
         ST_ELEM: begin
            case (step_ff[1:0])
               2'd0: begin
                  op_x      = LIMB_W'(a_mag_ff);
                  op_y      = LIMB_W'(a_mag_ff);
                  dst_issue = DST_NORM_A;
               end
               2'd1: begin
                  op_x      = LIMB_W'(b_mag_ff);
                  op_y      = LIMB_W'(b_mag_ff);
                  dst_issue = DST_NORM_B;
               end
               2'd2: begin
                  op_x      = LIMB_W'(a_mag_ff);
                  op_y      = LIMB_W'(b_mag_ff);
                  dst_issue = DST_DOT;
                  neg_issue = neg_ab_ff;
               end
               default: begin
                  dst_issue = DST_NONE;
               end
            endcase
         end
         ST_MUL: begin
            if (!step_ff[3]) begin
               sh_issue = 2'({1'b0, step_ff[0]} + {1'b0, step_ff[1]});
               if (step_ff[2]) begin
                  op_x      = limb_of(dabs_ff, step_ff[0]);
                  op_y      = limb_of(dabs_ff, step_ff[1]);
                  dst_issue = DST_R;
               end else begin
                  op_x      = limb_of(norm_a_ff, step_ff[0]);
                  op_y      = limb_of(norm_b_ff, step_ff[1]);
                  dst_issue = DST_P;
               end
            end
         end
         default: begin
            dst_issue = DST_NONE;
         end
      endcase
   end

   always_comb begin
      case (sh_ff)
         SH_NONE: prod_shifted = ACC_W'(prod_ff);
         SH_ONE:  prod_shifted = ACC_W'(prod_ff) << LIMB_W;
         SH_TWO:  prod_shifted = ACC_W'(prod_ff) << (2 * LIMB_W);
         default: prod_shifted = '0;
      endcase
   end

   always_comb begin
      step_in       = '0;
      a_mag_in      = a_mag_ff;
      b_mag_in      = b_mag_ff;
      neg_ab_in     = neg_ab_ff;
      last_in       = last_ff;
      prod_in       = PROD_W'(op_x) * PROD_W'(op_y);
      dst_in        = dst_issue;
      sh_in         = sh_issue;
      neg_in        = neg_issue;
      dot_in        = dot_ff;
      norm_a_in     = norm_a_ff;
      norm_b_in     = norm_b_ff;
      count_in      = count_ff;
      ovf_in        = ovf_ff;
      dabs_in       = dabs_ff;
      p_in          = p_ff;
      r_in          = r_ff;
      t_in          = t_ff;
      u_in          = u_ff;
      tc_in         = tc_ff;
      uc_in         = uc_ff;
      q_in          = q_ff;
      bit_in        = bit_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_cosine_in = rsp_cosine_ff;
      rsp_status_in = rsp_status_ff;

      if (state_ff inside {ST_ELEM, ST_MUL}) begin
         step_in = step_ff + STEP_W'(1);
      end

      if (accept) begin
         a_mag_in  = req_elem_a[ELEM_W-1] ? (~req_elem_a + MAG_W'(1)) : req_elem_a;
         b_mag_in  = req_elem_b[ELEM_W-1] ? (~req_elem_b + MAG_W'(1)) : req_elem_b;
         neg_ab_in = req_elem_a[ELEM_W-1] ^ req_elem_b[ELEM_W-1];
         last_in   = req_last;
         if (full) begin
            ovf_in = 1'b1;
         end else begin
            count_in = count_ff + CNT_W'(1);
         end
      end

      case (dst_ff)
         DST_NORM_A: norm_a_in = norm_a_ff + prod_ff[NORM_W-1:0];
         DST_NORM_B: norm_b_in = norm_b_ff + prod_ff[NORM_W-1:0];
         DST_DOT:    dot_in = neg_ff ? (dot_ff - DOT_W'(prod_ff)) : (dot_ff + DOT_W'(prod_ff));
         DST_P:      p_in = p_ff + prod_shifted;
         DST_R:      r_in = r_ff + prod_shifted;
         default:    p_in = p_ff;
      endcase

      if (state_ff == ST_CHECK) begin
         if (ovf_ff) begin
            res_status_in = STATUS_LONG;
         end else if (norm_zero) begin
            res_status_in = STATUS_ZERO;
         end else begin
            res_status_in = STATUS_OK;
         end
         dabs_in = dot_ff[DOT_W-1] ? dot_neg[NORM_W-1:0] : dot_ff[NORM_W-1:0];
         p_in    = '0;
         r_in    = '0;
         t_in    = '0;
         u_in    = '0;
         q_in    = '0;
         bit_in  = Q_TOP_BIT;
      end

      if (state_ff == ST_SADD) begin
         tc_in = t_ff + (u_ff << ({1'b0, bit_ff} + 5'd1)) + (p_wide << {bit_ff, 1'b0});
         uc_in = u_ff + (p_wide << bit_ff);
      end

      if (state_ff == ST_SCMP) begin
         if (tc_ff <= r_scaled) begin
            t_in         = tc_ff;
            u_in         = uc_ff;
            q_in[bit_ff] = 1'b1;
         end
         if (bit_ff != '0) begin
            bit_in = bit_ff - BIT_W'(1);
         end
      end

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (done_go) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = res_status_ff;
         if (res_status_ff != STATUS_OK) begin
            rsp_cosine_in = '0;
         end else if (dot_ff[DOT_W-1]) begin
            rsp_cosine_in = ~q_ext + COS_W'(1);
         end else begin
            rsp_cosine_in = q_ext;
         end
         dot_in    = '0;
         norm_a_in = '0;
         norm_b_in = '0;
         count_in  = '0;
         ovf_in    = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         dst_ff       <= DST_NONE;
         dot_ff       <= '0;
         norm_a_ff    <= '0;
         norm_b_ff    <= '0;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         dst_ff       <= dst_in;
         dot_ff       <= dot_in;
         norm_a_ff    <= norm_a_in;
         norm_b_ff    <= norm_b_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      a_mag_ff      <= a_mag_in;
      b_mag_ff      <= b_mag_in;
      neg_ab_ff     <= neg_ab_in;
      last_ff       <= last_in;
      prod_ff       <= prod_in;
      sh_ff         <= sh_in;
      neg_ff        <= neg_in;
      dabs_ff       <= dabs_in;
      p_ff          <= p_in;
      r_ff          <= r_in;
      t_ff          <= t_in;
      u_ff          <= u_in;
      tc_ff         <= tc_in;
      uc_ff         <= uc_in;
      q_ff          <= q_in;
      bit_ff        <= bit_in;
      res_status_ff <= res_status_in;
      rsp_cosine_ff <= rsp_cosine_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_cosine = rsp_cosine_ff;
   assign rsp_status = rsp_status_ff;

endmodule

`default_nettype wire
